// ===== hw/rtl/cpu6_pkg.sv =====
// ----------------------------------------------------------------------------
// cpu6_pkg
// Shared types and constants for the 6502-subset core: item structs, item
// kinds, result status codes, opcodes, flag bits and fixed addresses.
// ----------------------------------------------------------------------------
package cpu6_pkg;

    // Fixed widths
    localparam int ADDR_W         = 16;
    localparam int COUNT_BITS_DEF = 32;
    localparam int EXEC_CNT_W     = 32;

    // Item kinds
    localparam logic [1:0] KIND_EXEC  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_EXEC   = 2'd0;
    localparam logic [1:0] ST_TRAP   = 2'd1;
    localparam logic [1:0] ST_UNIMPL = 2'd2;
    localparam logic [1:0] ST_MEM    = 2'd3;

    // Opcodes
    localparam logic [7:0] OP_BRK     = 8'h00;
    localparam logic [7:0] OP_TRAP    = 8'h02;
    localparam logic [7:0] OP_JSR     = 8'h20;
    localparam logic [7:0] OP_RTI     = 8'h40;
    localparam logic [7:0] OP_JMP     = 8'h4C;
    localparam logic [7:0] OP_RTS     = 8'h60;
    localparam logic [7:0] OP_STA_ABS = 8'h8D;
    localparam logic [7:0] OP_LDA_IMM = 8'hA9;
    localparam logic [7:0] OP_LDA_ABS = 8'hAD;
    localparam logic [7:0] OP_NOP     = 8'hEA;

    // Flag bits
    localparam logic [7:0] FLAG_N = 8'h80;
    localparam logic [7:0] FLAG_B = 8'h10;
    localparam logic [7:0] FLAG_I = 8'h04;
    localparam logic [7:0] FLAG_Z = 8'h02;

    // Fixed addresses and reset values
    localparam logic [7:0]  STACK_PAGE    = 8'h01;
    localparam logic [15:0] VEC_IRQ_LO    = 16'hFFFE;
    localparam logic [15:0] VEC_IRQ_HI    = 16'hFFFF;
    localparam logic [15:0] START_PC_RST  = 16'h2000;
    localparam logic [7:0]  P_RST         = 8'h24;
    localparam logic [7:0]  SP_RST        = 8'hFD;

    // Input item
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  data;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  read_data;
        logic [15:0] trap_address;
        logic [15:0] program_counter;
        logic [7:0]  accumulator;
        logic [7:0]  flags;
        logic [7:0]  stack_pointer;
        logic [31:0] executed_count;
    } t_out_item;

endpackage

// ===== hw/rtl/cpu6_mem.sv =====
// ----------------------------------------------------------------------------
// cpu6_mem
// 64K x 8 single-port memory: one write or one read per cycle, read data
// registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module cpu6_mem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [cpu6_pkg::ADDR_W-1:0] i_addr,
    input  logic [7:0]                  i_wdata,
    output logic [7:0]                  o_rdata
);

    localparam int DEPTH = 1 << cpu6_pkg::ADDR_W;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/cpu6_step_unit.sv =====
// ----------------------------------------------------------------------------
// cpu6_step_unit
// Shared 16-bit increment/decrement unit. Steps PC, SP (low byte) and the
// return addresses of BRK and JSR.
// ----------------------------------------------------------------------------
module cpu6_step_unit (
    input  logic [15:0] i_x,
    input  logic        i_dec,
    output logic [15:0] o_y
);

    // one add per use, wraps at 16 bits
    always_comb begin
        if (i_dec) begin
            o_y = i_x - 16'd1;
        end else begin
            o_y = i_x + 16'd1;
        end
    end

endmodule

// ===== hw/rtl/cpu6502_subset_core.sv =====
// ----------------------------------------------------------------------------
// cpu6502_subset_core
// Small 6502-subset processor with its own 64K byte memory. Each item writes
// a byte, reads a byte or steps one instruction, and returns one result.
//
//  channel | signals                         | handshake
//  --------+---------------------------------+-------------------------------
//  item in | i_item (t_in_item)              | i_start & !o_busy
//  result  | o_result (t_out_item)           | o_done, one cycle, no stall
//  config  | i_cfg_data[15:0] (start_pc)     | i_cfg_valid & o_cfg_ready
//
// Sequencing: instructions run from the shortest (NOP, trap,
// unimplemented) up to the longest (BRK); the single memory port paces
// them: every fetch, operand, stack and vector byte is one access.
// Result is strobed in the last cycle; the next item is taken after that.
// Reset: synchronous, active low; in the cycle after reset PC is loaded from
// start_pc, busy meanwhile. Memory content is undefined until written.
// The receiver cannot stall; config is always ready.
// ----------------------------------------------------------------------------
module cpu6502_subset_core #(
    parameter int COUNT_BITS = cpu6_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  cpu6_pkg::t_in_item  i_item,
    output logic                o_busy,
    output logic                o_done,
    output cpu6_pkg::t_out_item o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);

    // Sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_MEMOP   = 5'd1;
    localparam logic [4:0] S_MEMRD   = 5'd2;
    localparam logic [4:0] S_FETCH   = 5'd3;
    localparam logic [4:0] S_DECODE  = 5'd4;
    localparam logic [4:0] S_IMM     = 5'd5;
    localparam logic [4:0] S_IMM_D   = 5'd6;
    localparam logic [4:0] S_OPL     = 5'd7;
    localparam logic [4:0] S_OPH     = 5'd8;
    localparam logic [4:0] S_OPD     = 5'd9;
    localparam logic [4:0] S_LDA_R   = 5'd10;
    localparam logic [4:0] S_LDA_D   = 5'd11;
    localparam logic [4:0] S_STA_W   = 5'd12;
    localparam logic [4:0] S_JSR_PH  = 5'd13;
    localparam logic [4:0] S_JSR_PL  = 5'd14;
    localparam logic [4:0] S_BRK_PH  = 5'd15;
    localparam logic [4:0] S_BRK_PL  = 5'd16;
    localparam logic [4:0] S_BRK_PP  = 5'd17;
    localparam logic [4:0] S_VEC_L   = 5'd18;
    localparam logic [4:0] S_VEC_H   = 5'd19;
    localparam logic [4:0] S_VEC_D   = 5'd20;
    localparam logic [4:0] S_RTI_P   = 5'd21;
    localparam logic [4:0] S_RTI_PD  = 5'd22;
    localparam logic [4:0] S_PULL_L  = 5'd23;
    localparam logic [4:0] S_PULL_H  = 5'd24;
    localparam logic [4:0] S_PULL_D  = 5'd25;
    localparam logic [4:0] S_RTS_INC = 5'd26;
    localparam logic [4:0] S_DONE    = 5'd27;

    // Control and architectural registers
    logic [4:0]            r_state, n_state;
    logic                  r_boot;
    logic [15:0]           r_start_pc;
    logic [15:0]           r_pc, n_pc;
    logic [7:0]            r_a, n_a;
    logic [7:0]            r_p, n_p;
    logic [7:0]            r_sp, n_sp;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;

    // Per-item working registers
    logic [1:0]  r_kind, n_kind;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_data, n_data;
    logic [7:0]  r_op, n_op;
    logic [15:0] r_at, n_at;
    logic [7:0]  r_lo, n_lo;
    logic [15:0] r_tmp, n_tmp;
    logic [15:0] r_ret, n_ret;
    logic [1:0]  r_status, n_status;
    logic [7:0]  r_rd, n_rd;
    logic [15:0] r_where, n_where;

    // Memory port and shared step unit
    logic        mem_we;
    logic [15:0] mem_addr;
    logic [7:0]  mem_wdata;
    logic [7:0]  mem_rdata;
    logic        u_src_sp;
    logic        u_dec;
    logic [15:0] u_x;
    logic [15:0] u_y;
    logic [15:0] stack_addr;
    logic [15:0] word_in;
    logic        accept;
    logic [7:0]  ld_val;
    logic [63:0] cnt_ext;

    cpu6_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    cpu6_step_unit u_step (
        .i_x   (u_x),
        .i_dec (u_dec),
        .o_y   (u_y)
    );

    assign o_busy      = r_boot | (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start & ~o_busy;
    assign stack_addr  = {cpu6_pkg::STACK_PAGE, r_sp};
    assign word_in     = {mem_rdata, r_lo};
    assign u_x         = u_src_sp ? {8'h00, r_sp} : r_pc;

    // Step unit operand select
    always_comb begin
        u_src_sp = 1'b0;
        u_dec    = 1'b0;
        unique case (r_state)
            S_DECODE: begin
                u_src_sp = (mem_rdata == cpu6_pkg::OP_RTI) ||
                           (mem_rdata == cpu6_pkg::OP_RTS);
            end
            S_OPD: begin
                u_dec = 1'b1;
            end
            S_JSR_PH, S_JSR_PL, S_BRK_PH, S_BRK_PL, S_BRK_PP: begin
                u_src_sp = 1'b1;
                u_dec    = 1'b1;
            end
            S_RTI_P, S_RTI_PD, S_PULL_L: begin
                u_src_sp = 1'b1;
            end
            default: begin
                u_src_sp = 1'b0;
            end
        endcase
    end

    // Memory access select
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_pc;
        mem_wdata = r_a;
        unique case (r_state)
            S_MEMOP: begin
                mem_we    = (r_kind == cpu6_pkg::KIND_WRITE);
                mem_addr  = r_addr;
                mem_wdata = r_data;
            end
            S_LDA_R: mem_addr = r_tmp;
            S_STA_W: begin
                mem_we   = 1'b1;
                mem_addr = r_tmp;
            end
            S_JSR_PH, S_BRK_PH: begin
                mem_we    = 1'b1;
                mem_addr  = stack_addr;
                mem_wdata = r_ret[15:8];
            end
            S_JSR_PL, S_BRK_PL: begin
                mem_we    = 1'b1;
                mem_addr  = stack_addr;
                mem_wdata = r_ret[7:0];
            end
            S_BRK_PP: begin
                mem_we    = 1'b1;
                mem_addr  = stack_addr;
                mem_wdata = r_p | cpu6_pkg::FLAG_B;
            end
            S_VEC_L: mem_addr = cpu6_pkg::VEC_IRQ_LO;
            S_VEC_H: mem_addr = cpu6_pkg::VEC_IRQ_HI;
            S_RTI_P, S_RTI_PD, S_PULL_L, S_PULL_H: mem_addr = stack_addr;
            default: mem_addr = r_pc;
        endcase
    end

    // LDA result value (the N/Z update is done in the sequencer)
    always_comb begin
        ld_val = mem_rdata;
    end

    // Sequencer next state
    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_a      = r_a;
        n_p      = r_p;
        n_sp     = r_sp;
        n_cnt    = r_cnt;
        n_kind   = r_kind;
        n_addr   = r_addr;
        n_data   = r_data;
        n_op     = r_op;
        n_at     = r_at;
        n_lo     = r_lo;
        n_tmp    = r_tmp;
        n_ret    = r_ret;
        n_status = r_status;
        n_rd     = r_rd;
        n_where  = r_where;
        unique case (r_state)
            S_IDLE: begin
                if (r_boot) begin
                    n_pc = r_start_pc;
                end else if (accept) begin
                    n_kind  = i_item.kind;
                    n_addr  = i_item.address;
                    n_data  = i_item.data;
                    n_rd    = 8'h00;
                    n_where = 16'h0000;
                    if (i_item.kind == cpu6_pkg::KIND_EXEC) begin
                        n_status = cpu6_pkg::ST_EXEC;
                        n_state  = S_FETCH;
                    end else begin
                        n_status = cpu6_pkg::ST_MEM;
                        n_state  = S_MEMOP;
                    end
                end
            end
            S_MEMOP: begin
                n_state = (r_kind == cpu6_pkg::KIND_READ) ? S_MEMRD : S_DONE;
            end
            S_MEMRD: begin
                n_rd    = mem_rdata;
                n_state = S_DONE;
            end
            S_FETCH: begin
                n_at    = r_pc;
                n_pc    = u_y;
                n_state = S_DECODE;
            end
            S_DECODE: begin
                n_op = mem_rdata;
                if (mem_rdata != cpu6_pkg::OP_TRAP) begin
                    n_cnt = r_cnt + COUNT_BITS'(1);
                end
                unique case (mem_rdata)
                    cpu6_pkg::OP_TRAP: begin
                        n_status = cpu6_pkg::ST_TRAP;
                        n_where  = r_at;
                        n_state  = S_DONE;
                    end
                    cpu6_pkg::OP_NOP: n_state = S_DONE;
                    cpu6_pkg::OP_BRK: begin
                        n_ret   = u_y;
                        n_state = S_BRK_PH;
                    end
                    cpu6_pkg::OP_RTI: begin
                        n_sp    = u_y[7:0];
                        n_state = S_RTI_P;
                    end
                    cpu6_pkg::OP_RTS: begin
                        n_sp    = u_y[7:0];
                        n_state = S_PULL_L;
                    end
                    cpu6_pkg::OP_LDA_IMM: n_state = S_IMM;
                    cpu6_pkg::OP_LDA_ABS, cpu6_pkg::OP_STA_ABS,
                    cpu6_pkg::OP_JMP, cpu6_pkg::OP_JSR: n_state = S_OPL;
                    default: begin
                        n_pc     = r_at;
                        n_status = cpu6_pkg::ST_UNIMPL;
                        n_where  = r_at;
                        n_state  = S_DONE;
                    end
                endcase
            end
            S_IMM: begin
                n_pc    = u_y;
                n_state = S_IMM_D;
            end
            S_IMM_D, S_LDA_D: begin
                n_a = ld_val;
                n_p = (r_p & ~(cpu6_pkg::FLAG_N | cpu6_pkg::FLAG_Z))
                    | ((ld_val == 8'h00) ? cpu6_pkg::FLAG_Z : 8'h00)
                    | (ld_val[7] ? cpu6_pkg::FLAG_N : 8'h00);
                n_state = S_DONE;
            end
            S_OPL: begin
                n_pc    = u_y;
                n_state = S_OPH;
            end
            S_OPH: begin
                n_lo    = mem_rdata;
                n_pc    = u_y;
                n_state = S_OPD;
            end
            S_OPD: begin
                n_tmp = word_in;
                unique case (r_op)
                    cpu6_pkg::OP_JMP: begin
                        n_pc    = word_in;
                        n_state = S_DONE;
                    end
                    cpu6_pkg::OP_LDA_ABS: n_state = S_LDA_R;
                    cpu6_pkg::OP_STA_ABS: n_state = S_STA_W;
                    default: begin
                        n_ret   = u_y;
                        n_state = S_JSR_PH;
                    end
                endcase
            end
            S_LDA_R: n_state = S_LDA_D;
            S_STA_W: n_state = S_DONE;
            S_JSR_PH: begin
                n_sp    = u_y[7:0];
                n_state = S_JSR_PL;
            end
            S_JSR_PL: begin
                n_sp    = u_y[7:0];
                n_pc    = r_tmp;
                n_state = S_DONE;
            end
            S_BRK_PH: begin
                n_sp    = u_y[7:0];
                n_state = S_BRK_PL;
            end
            S_BRK_PL: begin
                n_sp    = u_y[7:0];
                n_state = S_BRK_PP;
            end
            S_BRK_PP: begin
                n_sp    = u_y[7:0];
                n_p     = r_p | cpu6_pkg::FLAG_I;
                n_state = S_VEC_L;
            end
            S_VEC_L: n_state = S_VEC_H;
            S_VEC_H: begin
                n_lo    = mem_rdata;
                n_state = S_VEC_D;
            end
            S_VEC_D: begin
                n_pc    = word_in;
                n_state = S_DONE;
            end
            S_RTI_P: begin
                n_sp    = u_y[7:0];
                n_state = S_RTI_PD;
            end
            S_RTI_PD: begin
                n_p     = mem_rdata;
                n_sp    = u_y[7:0];
                n_state = S_PULL_H;
            end
            S_PULL_L: begin
                n_sp    = u_y[7:0];
                n_state = S_PULL_H;
            end
            S_PULL_H: begin
                n_lo    = mem_rdata;
                n_state = S_PULL_D;
            end
            S_PULL_D: begin
                n_pc    = word_in;
                n_state = (r_op == cpu6_pkg::OP_RTS) ? S_RTS_INC : S_DONE;
            end
            S_RTS_INC: begin
                n_pc    = u_y;
                n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control and architectural state with reset, all but PC
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_boot     <= 1'b1;
            r_start_pc <= cpu6_pkg::START_PC_RST;
            r_a        <= 8'h00;
            r_p        <= cpu6_pkg::P_RST;
            r_sp       <= cpu6_pkg::SP_RST;
            r_cnt      <= '0;
        end else begin
            r_state <= n_state;
            r_boot  <= 1'b0;
            r_a     <= n_a;
            r_p     <= n_p;
            r_sp    <= n_sp;
            r_cnt   <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                r_start_pc <= i_cfg_data;
            end
        end
    end

    // Working registers and PC, no reset; PC is loaded in the cycle after reset, the rest during the item
    always_ff @(posedge i_clk) begin
        r_pc     <= n_pc;
        r_kind   <= n_kind;
        r_addr   <= n_addr;
        r_data   <= n_data;
        r_op     <= n_op;
        r_at     <= n_at;
        r_lo     <= n_lo;
        r_tmp    <= n_tmp;
        r_ret    <= n_ret;
        r_status <= n_status;
        r_rd     <= n_rd;
        r_where  <= n_where;
    end

    // Result
    assign cnt_ext = 64'(r_cnt);
    assign o_done  = (r_state == S_DONE);

    always_comb begin
        o_result.status          = r_status;
        o_result.read_data       = r_rd;
        o_result.trap_address    = r_where;
        o_result.program_counter = r_pc;
        o_result.accumulator     = r_a;
        o_result.flags           = r_p;
        o_result.stack_pointer   = r_sp;
        o_result.executed_count  = cnt_ext[cpu6_pkg::EXEC_CNT_W-1:0];
    end

`ifndef SYNTH
    a_done_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_accept_busy : assert property (@(posedge i_clk)
        accept |=> o_busy)
        else $error("block not busy after taking an item");

    a_trap_pc : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == cpu6_pkg::ST_TRAP) |->
        (o_result.program_counter == 16'(o_result.trap_address + 16'd1)))
        else $error("trap must leave PC one past the opcode");

    a_unimpl_pc : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == cpu6_pkg::ST_UNIMPL) |->
        (o_result.program_counter == o_result.trap_address))
        else $error("unimplemented opcode must leave PC on the opcode");

    a_rst_quiet : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");
`endif

endmodule
